// File: rtl/fbd_pkg.sv
// Package for the page-organized framebuffer with dirty box.
// Holds command and color codes, field widths and the control state type.
// No dependencies.
package fbd_pkg;

  localparam int POS_W  = 16;  // signed logical coordinate
  localparam int CMD_W  = 3;
  localparam int CLR_W  = 2;
  localparam int PAGE_W = 3;
  localparam int X_W    = 8;   // physical column
  localparam int Y_W    = 6;   // physical row
  localparam int BYTE_W = 8;

  localparam logic [CMD_W-1:0] CMD_DRAW  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TAKE  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

  localparam logic [CLR_W-1:0] COLOR_WHITE  = 2'd0;
  localparam logic [CLR_W-1:0] COLOR_BLACK  = 2'd1;
  localparam logic [CLR_W-1:0] COLOR_INVERT = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_CLEAR = 3'b100
  } state_t;

endpackage

// File: rtl/fbd_if.sv
// Valid/ready channel interfaces for the framebuffer command and result streams.
// Depends on fbd_pkg for the field widths.
interface fbd_cmd_if import fbd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic [CLR_W-1:0]         color;
  logic [PAGE_W-1:0]        page_index;
  logic [X_W-1:0]           column_index;

  modport source (output valid, cmd, pos_x, pos_y, color, page_index, column_index,
                  input ready);
  modport sink   (input valid, cmd, pos_x, pos_y, color, page_index, column_index,
                  output ready);
endinterface

interface fbd_rsp_if import fbd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              pixel_set;
  logic [BYTE_W-1:0] byte_value;
  logic [X_W-1:0]    box_x_min;
  logic [X_W-1:0]    box_x_max;
  logic [Y_W-1:0]    box_y_min;
  logic [Y_W-1:0]    box_y_max;

  modport source (output valid, pixel_set, byte_value, box_x_min, box_x_max,
                  box_y_min, box_y_max, input ready);
  modport sink   (input valid, pixel_set, byte_value, box_x_min, box_x_max,
                  box_y_min, box_y_max, output ready);
endinterface

// File: rtl/fbd_ram.sv
// Generic single-clock RAM, one write port and one read port with registered read data.
// No dependencies.
module fbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/page_framebuffer_with_dirty_box.sv
// Top level of the page-organized monochrome framebuffer with dirty box.
// Depends on fbd_pkg, fbd_cmd_if / fbd_rsp_if and fbd_ram.
//
//   channel  | direction | handshake       | contents
//   ---------+-----------+-----------------+-------------------------------------------
//   cmd_ch   | in        | valid / ready   | cmd, pos_x, pos_y, color, page/column index
//   rsp_ch   | out       | valid / ready   | pixel_set, byte_value, dirty box corners
//   cfg      | in        | cfg_we          | rotation (2 bits)
//
// Draw, query, take box, read byte and unused commands: the accept cycle addresses the
// frame RAM, and the execute state reads the registered byte, writes a drawn byte back
// and loads the output register.
// Clear all walks the sweep over every byte through the single RAM write port, one byte per
// cycle, and then passes through the execute state to give its result.
// After reset the same sweep zeroes the RAM, and cmd_ch.ready stays low until it ends.
// A result waits in the output register until taken; the block keeps accepting. An item
// whose result finds that register still full waits in the execute cycle, holding its
// RAM read address so its read data stays valid.
module page_framebuffer_with_dirty_box import fbd_pkg::*; #(
  parameter int SCREEN_WIDTH  = 192,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic            clk,
  input  logic            rst,
  fbd_cmd_if.sink         cmd_ch,
  fbd_rsp_if.source       rsp_ch,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_data
);

  localparam int PAGE_COUNT  = (SCREEN_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = SCREEN_WIDTH * PAGE_COUNT;
  localparam int ADDR_W      = $clog2(STORE_BYTES);

  localparam logic [X_W-1:0]    X_LAST    = X_W'(SCREEN_WIDTH - 1);
  localparam logic [Y_W-1:0]    Y_LAST    = Y_W'(SCREEN_HEIGHT - 1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(STORE_BYTES - 1);

  // Configuration.
  logic [1:0] rotation;

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation <= 2'd0;
    end else if (cfg_we) begin
      rotation <= cfg_data;
    end
  end

  // Front end: turn the incoming logical coordinates into a physical pixel and byte
  // address. The bounds check uses the rotated width and height; out-of-bounds pixels
  // get don't-care coordinates that the in_bounds flag gates later.
  logic [POS_W-1:0]  log_w;
  logic [POS_W-1:0]  log_h;
  logic              in_bounds_c;
  logic [X_W-1:0]    px_c;
  logic [Y_W-1:0]    py_c;
  logic [ADDR_W-1:0] pix_addr_c;
  logic [ADDR_W-1:0] byte_addr_c;
  logic              byte_ok_c;
  logic [ADDR_W-1:0] acc_addr_c;

  assign log_w = rotation[0] ? POS_W'(SCREEN_HEIGHT) : POS_W'(SCREEN_WIDTH);
  assign log_h = rotation[0] ? POS_W'(SCREEN_WIDTH)  : POS_W'(SCREEN_HEIGHT);

  assign in_bounds_c = !cmd_ch.pos_x[POS_W-1] && !cmd_ch.pos_y[POS_W-1] &&
                       (POS_W'(cmd_ch.pos_x) < log_w) && (POS_W'(cmd_ch.pos_y) < log_h);

  always_comb begin
    case (rotation)
      2'd1: begin
        px_c = X_LAST - cmd_ch.pos_y[X_W-1:0];
        py_c = cmd_ch.pos_x[Y_W-1:0];
      end
      2'd2: begin
        px_c = X_LAST - cmd_ch.pos_x[X_W-1:0];
        py_c = Y_LAST - cmd_ch.pos_y[Y_W-1:0];
      end
      2'd3: begin
        px_c = cmd_ch.pos_y[X_W-1:0];
        py_c = Y_LAST - cmd_ch.pos_x[Y_W-1:0];
      end
      default: begin
        px_c = cmd_ch.pos_x[X_W-1:0];
        py_c = cmd_ch.pos_y[Y_W-1:0];
      end
    endcase
  end

  // Page-organized layout: one byte holds eight rows of one column.
  assign pix_addr_c  = ADDR_W'(px_c) + ADDR_W'(py_c[Y_W-1:3]) * ADDR_W'(SCREEN_WIDTH);
  assign byte_addr_c = ADDR_W'(cmd_ch.column_index) +
                       ADDR_W'(cmd_ch.page_index) * ADDR_W'(SCREEN_WIDTH);
  assign byte_ok_c   = ({1'b0, cmd_ch.page_index} < 4'(PAGE_COUNT)) &&
                       (cmd_ch.column_index < X_W'(SCREEN_WIDTH));
  assign acc_addr_c  = (cmd_ch.cmd == CMD_READ) ? byte_addr_c : pix_addr_c;

  // Control and item registers.
  state_t            state;
  state_t            state_next;
  logic              clear_emit;   // clear sweep was started by a command, not by reset
  logic [ADDR_W-1:0] clr_cnt;
  logic [CMD_W-1:0]  cmd_q;
  logic [CLR_W-1:0]  color_q;
  logic              in_bounds_q;
  logic              byte_ok_q;
  logic [X_W-1:0]    px_q;
  logic [Y_W-1:0]    py_q;
  logic [ADDR_W-1:0] addr_q;

  logic [X_W-1:0]    dirty_x_low;
  logic [X_W-1:0]    dirty_x_high;
  logic [Y_W-1:0]    dirty_y_low;
  logic [Y_W-1:0]    dirty_y_high;

  logic              accept;
  logic              out_free;
  logic              finish;
  logic              clr_done;

  assign cmd_ch.ready = (state == S_IDLE);
  assign accept       = cmd_ch.valid && cmd_ch.ready;
  assign out_free     = !rsp_ch.valid || rsp_ch.ready;
  assign finish       = (state == S_EXEC) && out_free;
  assign clr_done     = (state == S_CLEAR) && (clr_cnt == ADDR_LAST);

  // Frame RAM. Reads are addressed from the command port in the accept cycle and from
  // the held item address afterwards, so a stalled item keeps valid read data.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [BYTE_W-1:0] ram_rdata;
  logic [BYTE_W-1:0] bit_mask;
  logic [BYTE_W-1:0] new_byte;
  logic              draw_write;

  assign ram_raddr = (state == S_IDLE) ? acc_addr_c : addr_q;
  assign bit_mask  = BYTE_W'(1) << py_q[2:0];

  always_comb begin
    case (color_q)
      COLOR_WHITE:  new_byte = ram_rdata & ~bit_mask;
      COLOR_BLACK:  new_byte = ram_rdata | bit_mask;
      COLOR_INVERT: new_byte = ram_rdata ^ bit_mask;
      default:      new_byte = ram_rdata;
    endcase
  end

  // Color 3 leaves the byte alone, so no write is needed for it.
  assign draw_write = finish && (cmd_q == CMD_DRAW) && in_bounds_q &&
                      (color_q != 2'd3);
  assign ram_we     = (state == S_CLEAR) || draw_write;
  assign ram_waddr  = (state == S_CLEAR) ? clr_cnt : addr_q;
  assign ram_wdata  = (state == S_CLEAR) ? '0 : new_byte;

  fbd_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (cmd_ch.cmd == CMD_CLEAR) ? S_CLEAR : S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (clr_done) begin
          state_next = clear_emit ? S_EXEC : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clear_emit <= 1'b0;
      clr_cnt    <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        clear_emit <= (cmd_ch.cmd == CMD_CLEAR);
        clr_cnt    <= '0;
      end else if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q       <= cmd_ch.cmd;
      color_q     <= cmd_ch.color;
      in_bounds_q <= in_bounds_c;
      byte_ok_q   <= byte_ok_c;
      px_q        <= px_c;
      py_q        <= py_c;
      addr_q      <= acc_addr_c;
    end
  end

  // Dirty box. Reset and a clear set it to the whole screen, an in-bounds draw widens it by
  // min/max even when the color leaves the byte alone, and a take hands it out and empties it.
  always_ff @(posedge clk) begin
    if (rst) begin
      dirty_x_low  <= '0;
      dirty_x_high <= X_LAST;
      dirty_y_low  <= '0;
      dirty_y_high <= Y_LAST;
    end else if (finish) begin
      case (cmd_q)
        CMD_DRAW: begin
          if (in_bounds_q) begin
            if (px_q < dirty_x_low)  dirty_x_low  <= px_q;
            if (px_q > dirty_x_high) dirty_x_high <= px_q;
            if (py_q < dirty_y_low)  dirty_y_low  <= py_q;
            if (py_q > dirty_y_high) dirty_y_high <= py_q;
          end
        end
        CMD_CLEAR: begin
          dirty_x_low  <= '0;
          dirty_x_high <= X_LAST;
          dirty_y_low  <= '0;
          dirty_y_high <= Y_LAST;
        end
        CMD_TAKE: begin
          dirty_x_low  <= X_LAST;
          dirty_x_high <= '0;
          dirty_y_low  <= Y_LAST;
          dirty_y_high <= '0;
        end
        default: ;
      endcase
    end
  end

  // Output register. Every field is zero unless its command produced it.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_ch.valid <= 1'b0;
    end else if (finish) begin
      rsp_ch.valid <= 1'b1;
    end else if (rsp_ch.ready) begin
      rsp_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      rsp_ch.pixel_set  <= (cmd_q == CMD_QUERY) && in_bounds_q && ram_rdata[py_q[2:0]];
      rsp_ch.byte_value <= ((cmd_q == CMD_READ) && byte_ok_q) ? ram_rdata : '0;
      if (cmd_q == CMD_TAKE) begin
        rsp_ch.box_x_min <= dirty_x_low;
        rsp_ch.box_x_max <= dirty_x_high;
        rsp_ch.box_y_min <= dirty_y_low;
        rsp_ch.box_y_max <= dirty_y_high;
      end else begin
        rsp_ch.box_x_min <= '0;
        rsp_ch.box_x_max <= '0;
        rsp_ch.box_y_min <= '0;
        rsp_ch.box_y_max <= '0;
      end
    end
  end

endmodule

// File: rtl/fbd_checker.sv
// Port-level checker for the framebuffer top level, attached by the bind at the end.
// Depends on fbd_pkg for the field widths.
module fbd_port_checker import fbd_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic              pixel_set,
  input logic [BYTE_W-1:0] byte_value,
  input logic [X_W-1:0]    box_x_min,
  input logic [X_W-1:0]    box_x_max,
  input logic [Y_W-1:0]    box_y_min,
  input logic [Y_W-1:0]    box_y_max
);

  // Items accepted whose result has not been transferred yet.
  logic [1:0] pending;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else begin
      pending <= pending + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_set) && $stable(byte_value) &&
      $stable(box_x_min) && $stable(box_x_max) && $stable(box_y_min) && $stable(box_y_max))
    else $error("result changed while stalled");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("result without an accepted item");

  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && pixel_set |-> byte_value == '0 && box_x_max == '0 && box_y_max == '0)
    else $error("query result carries other fields");

  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !in_ready)
    else $error("input ready during reset clearing sweep");

endmodule

bind page_framebuffer_with_dirty_box fbd_port_checker u_fbd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (cmd_ch.valid),
  .in_ready   (cmd_ch.ready),
  .out_valid  (rsp_ch.valid),
  .out_ready  (rsp_ch.ready),
  .pixel_set  (rsp_ch.pixel_set),
  .byte_value (rsp_ch.byte_value),
  .box_x_min  (rsp_ch.box_x_min),
  .box_x_max  (rsp_ch.box_x_max),
  .box_y_min  (rsp_ch.box_y_min),
  .box_y_max  (rsp_ch.box_y_max)
);
